[hdl/dtb_pkg.sv]
// ----------------------------------------------------------------------------
// dtb_pkg: deadline timer bank shared definitions
// Widths, action codes, request/response payloads and controller interface.
// ----------------------------------------------------------------------------
package dtb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int IDX_W      = (NUM_TIMERS > 8) ? 3 :
	                            (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int ACT_W      = 3;
	localparam int TID_W      = 3;
	localparam int TIME_W     = 32;

	localparam logic [TIME_W-1:0] MAX_DELAY_RST = 32'h7FFF_FFFF;

	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RELOAD = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEACT  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SETEL  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd5;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [TID_W-1:0]  timer_index;
		logic [TIME_W-1:0] timeout_ms;
	} req_t;

	typedef struct packed {
		logic [TID_W-1:0]  timer_id;
		logic              is_active;
		logic              is_elapsed;
		logic              active_elapsed;
		logic [TIME_W-1:0] remaining_ms;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic stat;
	} cmd_t;

	typedef struct packed {
		logic out_hold;
	} sts_t;

endpackage

[hdl/dtb_ctrl.sv]
// ----------------------------------------------------------------------------
// dtb_ctrl: deadline timer bank controller
// Sequences one request through capture, update and status phases.
// ----------------------------------------------------------------------------
module dtb_ctrl import dtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_STAT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_STAT;
			end
			ST_STAT: begin
				if (!sts.out_hold) begin
					cmd.stat = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/dtb_datapath.sv]
// ----------------------------------------------------------------------------
// dtb_datapath: deadline timer bank datapath
// Tick counter, timer entries, remaining-time compare and response register.
// ----------------------------------------------------------------------------
module dtb_datapath import dtb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              max_delay_we,
	input  logic [TIME_W-1:0] max_delay_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp
);

	req_t              item_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] max_delay_q;
	logic [TIME_W-1:0] deadline_q [NUM_TIMERS];
	logic              active_q   [NUM_TIMERS];
	logic              elapsed_q  [NUM_TIMERS];
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [IDX_W-1:0]  idx;
	logic              in_range;
	logic [TIME_W-1:0] cur_deadline;
	logic [TIME_W-1:0] sum;
	logic [TIME_W-1:0] diff;
	logic [TIME_W-1:0] remain;
	logic              latch_en;
	logic              new_elapsed;

	assign idx          = item_q.timer_index[IDX_W-1:0];
	assign in_range     = ({29'd0, item_q.timer_index} < 32'(NUM_TIMERS));
	assign cur_deadline = deadline_q[idx];
	assign sum          = ((item_q.action == ACT_START) ? now_q : cur_deadline)
	                      + item_q.timeout_ms;
	assign diff         = cur_deadline - now_q;
	assign remain       = (diff > max_delay_q) ? '0 : diff;
	assign latch_en     = (item_q.action == ACT_START) || (item_q.action == ACT_RELOAD)
	                      || (item_q.action == ACT_QUERY);
	assign new_elapsed  = elapsed_q[idx] | (latch_en && (remain == '0));

	assign sts.out_hold = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.stat) begin
			rsp_q.timer_id       <= item_q.timer_index;
			rsp_q.is_active      <= in_range && active_q[idx];
			rsp_q.is_elapsed     <= !in_range || new_elapsed;
			rsp_q.active_elapsed <= in_range && active_q[idx] && new_elapsed;
			rsp_q.remaining_ms   <= in_range ? remain : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			max_delay_q <= MAX_DELAY_RST;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				deadline_q[i] <= '0;
				active_q[i]   <= 1'b0;
				elapsed_q[i]  <= 1'b1;
			end
		end else begin
			if (max_delay_we) begin
				max_delay_q <= max_delay_data;
			end
			if (cmd.exec) begin
				if (item_q.action == ACT_TICK) begin
					now_q <= now_q + 32'd1;
				end
				if (in_range) begin
					unique case (item_q.action)
						ACT_START, ACT_RELOAD: begin
							deadline_q[idx] <= sum;
							active_q[idx]   <= 1'b1;
							elapsed_q[idx]  <= 1'b0;
						end
						ACT_DEACT: begin
							active_q[idx]  <= 1'b0;
							elapsed_q[idx] <= 1'b1;
						end
						ACT_SETEL: begin
							active_q[idx]  <= 1'b1;
							elapsed_q[idx] <= 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			if (cmd.stat && in_range) begin
				elapsed_q[idx] <= new_elapsed;
			end
			if (cmd.stat) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/deadline_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// deadline_timer_bank_unit: bank of millisecond deadline timers
// Shared 32-bit tick counter with per-timer deadlines and latched elapsed flags.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, req): one action on the tick counter or
//   on one timer. rsp channel (rsp_valid/rsp_ready, rsp): the addressed
//   timer's status after the action, exactly one per request.
//   max_delay_we/max_delay_data write the wrap guard register;
//   write it only while no request is in flight.
//   A request is captured, then the action updates the counter or timer,
//   then the status phase registers the response. Requests do not overlap:
//   a new one is taken only after the capture, update and status phases
//   of the controller are done.
//   A new request is taken while a finished response still waits; if the
//   receiver stalls, the status phase holds until the response register
//   frees, and the response stays stable.
//   Reset: counter 0, all deadlines 0, all timers inactive and elapsed,
//   max_delay 0x7FFFFFFF. No clearing pass is needed.
// ----------------------------------------------------------------------------
module deadline_timer_bank_unit import dtb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              max_delay_we,
	input  logic [TIME_W-1:0] max_delay_data
);

	cmd_t cmd;
	sts_t sts;

	dtb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dtb_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.cmd            (cmd),
		.sts            (sts),
		.max_delay_we   (max_delay_we),
		.max_delay_data (max_delay_data),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp)
	);

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.stat}))
		else $error("controller issued overlapping commands");

	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> cmd.exec)
		else $error("accepted request not executed next cycle");

	a_stat_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stat |-> !(rsp_valid && !rsp_ready))
		else $error("response register overwritten while stalled");

	a_stat_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stat |=> rsp_valid)
		else $error("status phase did not produce a response");

endmodule
